// ===== hdl/resource_map_allocator_assert.svh =====
// Assertion macros shared by the allocator modules.
`ifndef RESOURCE_MAP_ALLOCATOR_ASSERT_SVH
`define RESOURCE_MAP_ALLOCATOR_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define RMA_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error(msg);

// The condition holds in the cycle after the trigger.
`define RMA_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== hdl/rma_pkg.sv =====
package rma_pkg;

   // Number of extent cells in the chain.
   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 31;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
   } extent_type;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [LEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== hdl/rma_cell.sv =====
module rma_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  rma_pkg::extent_type d,
   output rma_pkg::extent_type q
);
   import rma_pkg::*;

   extent_type entry_ff;

   // Each cell takes its right-hand neighbour's entry whenever the chain moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift) begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;

endmodule

// ===== hdl/rma_divider.sv =====
module rma_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  rma_pkg::div_req_type req,
   output rma_pkg::div_rsp_type rsp
);
   import rma_pkg::*;

   logic [LEN_W-1:0]     rem_ff;
   logic [LEN_W-1:0]     rem_in;
   logic [ADDR_W-1:0]    dvd_ff;
   logic [LEN_W-1:0]     dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [LEN_W:0]       trial;
   logic [LEN_W:0]       diff;

   // Restoring division, one quotient bit per cycle; only the remainder is kept.
   always_comb begin
      trial  = {rem_ff, dvd_ff[ADDR_W-1]};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = (trial >= {1'b0, dsr_ff}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff <= '0;
            dvd_ff <= req.dividend;
            dsr_ff <= req.divisor;
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[ADDR_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

   `include "resource_map_allocator_assert.svh"

   `RMA_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff, "divider done held")
   `RMA_ASSERT_SAME(a_done_idle, clock, reset, done_ff, !run_ff, "divider done while running")

endmodule

// ===== hdl/rma_control.sv =====
module rma_control (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [rma_pkg::ADDR_W-1:0]   req_address,
   input  logic [rma_pkg::LEN_W-1:0]    req_length,
   input  logic [rma_pkg::LEN_W-1:0]    req_alignment,
   input  rma_pkg::extent_type          head,
   input  rma_pkg::extent_type          nxt,
   output logic                         shift,
   output rma_pkg::extent_type          tail,
   output rma_pkg::div_req_type         div_req,
   input  rma_pkg::div_rsp_type         div_rsp,
   output logic                         rsp_strobe,
   output logic [rma_pkg::ADDR_W-1:0]   rsp_granted_addr,
   output logic                         rsp_done_ok,
   output logic                         rsp_extent_lost
);
   import rma_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_PREDIV, S_PDWAIT, S_ASCAN, S_ADIV, S_RSCAN, S_RDECIDE, S_REDIT
   } state_type;

   typedef enum logic [1:0] {M_COPY, M_SKIP, M_DELAY} mode_type;
   typedef enum logic [1:0] {K_REPLACE, K_MERGE, K_INSERT, K_REMOVE} kind_type;

   function automatic logic [ADDR_W-1:0] sat_add(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
      logic [ADDR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ADDR_W] ? '1 : s[ADDR_W-1:0];
   endfunction

   state_type         state_ff;
   mode_type          mode_ff, mode_in;
   extent_type        hold_ff, hold_in;
   logic [IDX_W-1:0]  step_ff;
   logic              op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  align_ff;
   logic [ADDR_W-1:0] rnd_ff;
   logic              rnd_valid_ff;
   logic [ADDR_W-1:0] div_x_ff;
   logic              used_ff;
   logic              scan_done_ff;
   logic              ok_ff;
   logic [ADDR_W-1:0] granted_ff;
   logic [ADDR_W-1:0] slack_ff;
   logic [ADDR_W-1:0] slack_st_ff;
   logic [ADDR_W-1:0] rel_addr_ff;
   logic [ADDR_W-1:0] rel_size_ff;
   logic [CNT_W-1:0]  i_ff, n_ff, p_ff;
   logic              stop_ff;
   extent_type        prev_ff, cur_ff, val_ff;
   kind_type          kind_ff;
   logic              rlost_ff;
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_ok_ff, rsp_lost_ff;

   logic              last;
   logic              used_now;
   logic              fixed_addr, per_div, need_div, evaluate, eval_ok;
   logic [ADDR_W-1:0] len32, a_end, a_sum, m_addr, off, rem_len;
   logic              brk, skip_c, fit, success, stop_now;
   extent_type        new_ext, skip_val, edit_val;
   logic              edit_here;
   kind_type          edit_kind;
   logic              mrg_l, mrg_r;
   kind_type          dec_kind;
   logic [CNT_W-1:0]  dec_p;
   extent_type        dec_val;
   logic              fin_ok;
   logic [ADDR_W-1:0] fin_slack, fin_st, fin_granted;
   logic [ADDR_W-1:0] rounded;

   // Allocation test on the entry at the head of the chain.
   always_comb begin
      last       = (step_ff == IDX_W'(ENTRIES - 1));
      used_now   = used_ff && (head.length != '0);
      len32      = {1'b0, len_ff};
      fixed_addr = (addr_ff != '0);
      per_div    = !fixed_addr && (align_ff != '0);
      evaluate   = used_now && !scan_done_ff;
      need_div   = evaluate && per_div && !rnd_valid_ff;
      eval_ok    = evaluate && !need_div;
      a_end      = head.start + head.length;
      a_sum      = addr_ff + len32;
      if (align_ff != '0) begin
         m_addr = rnd_ff;
      end else if (fixed_addr) begin
         m_addr = addr_ff;
      end else begin
         m_addr = head.start;
      end
      off     = m_addr - head.start;
      rem_len = head.length - off;
      fit     = !(off > head.length) && (rem_len >= len32);
      skip_c  = fixed_addr && (a_end < addr_ff);
      brk     = fixed_addr && ((head.start > addr_ff) || (!skip_c && (a_sum > a_end)));
      success = eval_ok && !brk && !skip_c && fit;
      stop_now = eval_ok && (brk || success);
      new_ext.start  = m_addr + len32;
      new_ext.length = rem_len - len32;
      rounded = div_x_ff - {1'b0, div_rsp.remainder};
   end

   // Stream editor: what goes back into the tail cell on each move.
   always_comb begin
      edit_here = 1'b0;
      edit_kind = K_REPLACE;
      edit_val  = new_ext;
      if (state_ff == S_ASCAN) begin
         edit_here = success;
         edit_kind = (new_ext.length != '0) ? K_REPLACE : K_REMOVE;
      end else if (state_ff == S_REDIT) begin
         edit_here = (CNT_W'(step_ff) == p_ff);
         edit_kind = kind_ff;
         edit_val  = val_ff;
      end
      skip_val = last ? '0 : nxt;
      mode_in  = mode_ff;
      hold_in  = hold_ff;
      tail     = head;
      if (edit_here) begin
         unique case (edit_kind)
            K_REPLACE: tail = edit_val;
            K_MERGE: begin
               tail    = edit_val;
               mode_in = M_SKIP;
            end
            K_INSERT: begin
               tail    = edit_val;
               hold_in = head;
               mode_in = M_DELAY;
            end
            K_REMOVE: begin
               tail    = skip_val;
               mode_in = M_SKIP;
            end
         endcase
      end else begin
         unique case (mode_ff)
            M_COPY: tail = head;
            M_SKIP: tail = skip_val;
            M_DELAY: begin
               tail    = hold_ff;
               hold_in = head;
            end
            default: tail = head;
         endcase
      end
      if (last) begin
         mode_in = M_COPY;
      end
      shift = ((state_ff == S_ASCAN) && !need_div) || (state_ff == S_RSCAN) ||
              (state_ff == S_REDIT);
   end

   // Release decision from the facts gathered on the scan pass.
   always_comb begin
      mrg_l = (i_ff != '0) && ((prev_ff.start + prev_ff.length) == rel_addr_ff);
      mrg_r = stop_ff && ((rel_addr_ff + rel_size_ff) == cur_ff.start);
      priority if (mrg_l && mrg_r) begin
         dec_kind       = K_MERGE;
         dec_p          = i_ff - 1'b1;
         dec_val.start  = prev_ff.start;
         dec_val.length = sat_add(sat_add(prev_ff.length, rel_size_ff), cur_ff.length);
      end else if (mrg_l) begin
         dec_kind       = K_REPLACE;
         dec_p          = i_ff - 1'b1;
         dec_val.start  = prev_ff.start;
         dec_val.length = sat_add(prev_ff.length, rel_size_ff);
      end else if (mrg_r) begin
         dec_kind       = K_REPLACE;
         dec_p          = i_ff;
         dec_val.start  = cur_ff.start - rel_size_ff;
         dec_val.length = sat_add(cur_ff.length, rel_size_ff);
      end else begin
         dec_kind       = K_INSERT;
         dec_p          = i_ff;
         dec_val.start  = rel_addr_ff;
         dec_val.length = rel_size_ff;
      end
      fin_ok      = ok_ff || success;
      fin_slack   = success ? off : slack_ff;
      fin_st      = success ? head.start : slack_st_ff;
      fin_granted = success ? m_addr : granted_ff;
   end

   always_comb begin
      div_req.start    = (state_ff == S_PREDIV) || ((state_ff == S_ASCAN) && need_div);
      div_req.dividend = ((state_ff == S_PREDIV) ? addr_ff : head.start) +
                         {1'b0, align_ff} - 32'd1;
      div_req.divisor  = align_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_COPY;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (shift) begin
            mode_ff <= mode_in;
            hold_ff <= hold_in;
            step_ff <= last ? '0 : step_ff + 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff        <= req_opcode;
                  addr_ff      <= req_address;
                  len_ff       <= req_length;
                  align_ff     <= req_alignment;
                  used_ff      <= 1'b1;
                  scan_done_ff <= 1'b0;
                  ok_ff        <= 1'b0;
                  granted_ff   <= '0;
                  slack_ff     <= '0;
                  rnd_valid_ff <= 1'b0;
                  i_ff         <= '0;
                  n_ff         <= '0;
                  stop_ff      <= 1'b0;
                  mode_ff      <= M_COPY;
                  step_ff      <= '0;
                  rel_addr_ff  <= req_address;
                  rel_size_ff  <= {1'b0, req_length};
                  if (req_opcode) begin
                     if (req_length == '0) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_addr_ff  <= '0;
                        rsp_ok_ff    <= 1'b0;
                        rsp_lost_ff  <= 1'b0;
                     end else begin
                        state_ff <= S_RSCAN;
                     end
                  end else if ((req_address != '0) && (req_alignment != '0)) begin
                     state_ff <= S_PREDIV;
                  end else begin
                     state_ff <= S_ASCAN;
                  end
               end
            end
            S_PREDIV: begin
               div_x_ff <= div_req.dividend;
               state_ff <= S_PDWAIT;
            end
            S_PDWAIT: begin
               if (div_rsp.done) begin
                  rnd_ff   <= rounded;
                  state_ff <= S_ASCAN;
               end
            end
            S_ASCAN: begin
               if (need_div) begin
                  div_x_ff <= div_req.dividend;
                  state_ff <= S_ADIV;
               end else begin
                  rnd_valid_ff <= 1'b0;
                  used_ff      <= used_now;
                  if (stop_now) begin
                     scan_done_ff <= 1'b1;
                  end
                  if (success) begin
                     ok_ff       <= 1'b1;
                     granted_ff  <= m_addr;
                     slack_ff    <= off;
                     slack_st_ff <= head.start;
                  end
                  if (last) begin
                     if (fin_ok && (fin_slack != '0)) begin
                        rel_addr_ff <= fin_st;
                        rel_size_ff <= fin_slack;
                        used_ff     <= 1'b1;
                        i_ff        <= '0;
                        n_ff        <= '0;
                        stop_ff     <= 1'b0;
                        state_ff    <= S_RSCAN;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        rsp_addr_ff  <= fin_ok ? fin_granted : '0;
                        rsp_ok_ff    <= fin_ok;
                        rsp_lost_ff  <= 1'b0;
                        state_ff     <= S_IDLE;
                     end
                  end
               end
            end
            S_ADIV: begin
               if (div_rsp.done) begin
                  rnd_ff       <= rounded;
                  rnd_valid_ff <= 1'b1;
                  state_ff     <= S_ASCAN;
               end
            end
            S_RSCAN: begin
               used_ff <= used_now;
               if (used_now) begin
                  n_ff <= n_ff + 1'b1;
                  if (!stop_ff) begin
                     if (head.start <= rel_addr_ff) begin
                        i_ff    <= i_ff + 1'b1;
                        prev_ff <= head;
                     end else begin
                        stop_ff <= 1'b1;
                        cur_ff  <= head;
                     end
                  end
               end
               if (last) begin
                  state_ff <= S_RDECIDE;
               end
            end
            S_RDECIDE: begin
               kind_ff  <= dec_kind;
               p_ff     <= dec_p;
               val_ff   <= dec_val;
               rlost_ff <= (dec_kind == K_INSERT) && (n_ff == CNT_W'(ENTRIES));
               mode_ff  <= M_COPY;
               state_ff <= S_REDIT;
            end
            S_REDIT: begin
               if (last) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_lost_ff  <= rlost_ff;
                  if (op_ff) begin
                     rsp_addr_ff <= '0;
                     rsp_ok_ff   <= !rlost_ff;
                  end else begin
                     rsp_addr_ff <= granted_ff;
                     rsp_ok_ff   <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_granted_addr = rsp_addr_ff;
   assign rsp_done_ok      = rsp_ok_ff;
   assign rsp_extent_lost  = rsp_lost_ff;

   `include "resource_map_allocator_assert.svh"

   `RMA_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid_ff, !busy, "result while busy")
   `RMA_ASSERT_NEXT(a_accept, clock, reset, start && !busy, busy || rsp_valid_ff, "request dropped")
   `RMA_ASSERT_SAME(a_div_wait, clock, reset, div_rsp.done, (state_ff == S_ADIV) || (state_ff == S_PDWAIT), "divider result unexpected")
   `RMA_ASSERT_SAME(a_delay_edit, clock, reset, mode_ff == M_DELAY, state_ff == S_REDIT, "insert outside edit pass")

endmodule

// ===== hdl/resource_map_allocator.sv =====
// A release scans the extent chain once to find its place, then makes a second pass that edits it.
// An allocation scans the chain once, waiting on the divider for each extent tried with an alignment
// (a fixed address waits once, before the scan); a release pass follows if leading slack goes back.
// Throughput: one request at a time; the passes of the extent chain and the divider set it.
// Reset (synchronous) empties the table; results are never stalled.
module resource_map_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [rma_pkg::ADDR_W-1:0] req_address,
   input  logic [rma_pkg::LEN_W-1:0]  req_length,
   input  logic [rma_pkg::LEN_W-1:0]  req_alignment,
   output logic                       rsp_strobe,
   output logic [rma_pkg::ADDR_W-1:0] rsp_granted_addr,
   output logic                       rsp_done_ok,
   output logic                       rsp_extent_lost
);
   import rma_pkg::*;

   // The free-extent table lives in a ring of cells. Every move takes each entry one cell
   // towards the head; the controller sees the head and its neighbour and feeds the tail,
   // so one full pass of ENTRIES moves brings the table back in order, edited on the way.
   extent_type  chain_q [ENTRIES];
   extent_type  tail;
   logic        shift;
   div_req_type div_req;
   div_rsp_type div_rsp;

   genvar k;
   generate
      for (k = 0; k < ENTRIES; k++) begin : g_cell
         if (k == ENTRIES - 1) begin : g_tail
            rma_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (shift),
               .d     (tail),
               .q     (chain_q[k])
            );
         end else begin : g_body
            rma_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (shift),
               .d     (chain_q[k+1]),
               .q     (chain_q[k])
            );
         end
      end
   endgenerate

   // The divider gives the remainder used to round a start up to the alignment.
   rma_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // The controller runs the scan, merge and insert passes and shapes each transfer.
   rma_control u_control (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_address      (req_address),
      .req_length       (req_length),
      .req_alignment    (req_alignment),
      .head             (chain_q[0]),
      .nxt              (chain_q[1]),
      .shift            (shift),
      .tail             (tail),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_strobe       (rsp_strobe),
      .rsp_granted_addr (rsp_granted_addr),
      .rsp_done_ok      (rsp_done_ok),
      .rsp_extent_lost  (rsp_extent_lost)
   );

endmodule
